>>> rtl/lzwe_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lzwe_pkg
// Shared types and constants of the byte-wise lzw encoder.
// ----------------------------------------------------------------------------
package lzwe_pkg;

	localparam int BYTE_W        = 8;
	localparam int CODE_W        = 12;
	localparam int NFC_W         = 13;
	localparam int PAIR_W        = CODE_W + BYTE_W;
	localparam int CODE_SPACE    = 4096;
	localparam int FIRST_LEARNED = 256;
	localparam int DICT_SIZE_DEF = 4096;
	localparam int IN_DEPTH_DEF  = 2;
	localparam int OUT_DEPTH_DEF = 4;

	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              end_of_stream;
	} in_item_t;

	typedef struct packed {
		logic [CODE_W-1:0] code_word;
		logic              last_code;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DICT,
		ST_CHECK,
		ST_LAST
	} core_state_t;

endpackage
`default_nettype wire

>>> rtl/lzw_byte_encoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lzw_byte_encoder
// Byte-wise lzw encoder: input queue, hashed dictionary engine, result queue.
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  input   | in_valid / in_ready | data_byte[7:0], end_of_stream
//  output  | out_valid/out_ready | code_word[11:0], last_code
//
//  a byte with a held prefix passes the engine states idle, dict and check, and
//  each extra probe of the hash table repeats dict and check; the first byte of
//  a stream only sets the prefix; the closing code of a stream adds the last state
//  after reset the hash table is swept, one slot a cycle (8192 slots at the
//  default size); no item is taken during the sweep
//  the engine starts an item only when the result queue has room for two codes
// ----------------------------------------------------------------------------
module lzw_byte_encoder
	import lzwe_pkg::*;
#(
	parameter int DICT_SIZE = DICT_SIZE_DEF,
	parameter int IN_DEPTH  = IN_DEPTH_DEF,
	parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [BYTE_W-1:0] data_byte,
	input  wire logic              end_of_stream,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic      [CODE_W-1:0] code_word,
	output logic                   last_code
);

	in_item_t  in_item;
	in_item_t  q_item;
	out_item_t res;
	out_item_t out_item;
	logic      ifq_ready;
	logic      q_valid;
	logic      q_pop;
	logic      res_push;
	logic      res_room;
	logic      sweep;

	assign in_item  = '{data_byte: data_byte, end_of_stream: end_of_stream};
	assign in_ready = ifq_ready && !sweep;

	lzwe_fifo #(
		.WIDTH ($bits(in_item_t)),
		.DEPTH (IN_DEPTH)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (in_valid && !sweep),
		.s_ready (ifq_ready),
		.s_data  (in_item),
		.m_valid (q_valid),
		.m_ready (q_pop),
		.m_data  (q_item),
		.room2   ()
	);

	lzwe_core #(
		.DICT_SIZE (DICT_SIZE)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (q_valid),
		.item       (q_item),
		.item_pop   (q_pop),
		.res_room   (res_room),
		.res_push   (res_push),
		.res        (res),
		.sweep      (sweep)
	);

	lzwe_fifo #(
		.WIDTH ($bits(out_item_t)),
		.DEPTH (OUT_DEPTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (res_push),
		.s_ready (),
		.s_data  (res),
		.m_valid (out_valid),
		.m_ready (out_ready),
		.m_data  (out_item),
		.room2   (res_room)
	);

	assign code_word = out_item.code_word;
	assign last_code = out_item.last_code;

endmodule
`default_nettype wire

>>> rtl/lzwe_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lzwe_fifo
// Small register queue with valid/ready on both sides and a two-slot room flag.
// ----------------------------------------------------------------------------
module lzwe_fifo
	import lzwe_pkg::*;
#(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_valid,
	output logic                  s_ready,
	input  wire logic [WIDTH-1:0] s_data,
	output logic                  m_valid,
	input  wire logic             m_ready,
	output logic      [WIDTH-1:0] m_data,
	output logic                  room2
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slots_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             push;
	logic             pop;

	assign s_ready = count_q != CW'(DEPTH);
	assign m_valid = count_q != '0;
	assign m_data  = slots_q[rd_ptr_q];
	assign room2   = count_q <= CW'(DEPTH - 2);
	assign push    = s_valid && s_ready;
	assign pop     = m_valid && m_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= s_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

>>> rtl/lzwe_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lzwe_core
// Back end: hashed dictionary lookup with linear probing, insert and emit.
// ----------------------------------------------------------------------------
module lzwe_core
	import lzwe_pkg::*;
#(
	parameter int DICT_SIZE = DICT_SIZE_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      item_valid,
	input  wire in_item_t  item,
	output logic           item_pop,
	input  wire logic      res_room,
	output logic           res_push,
	output out_item_t      res,
	output logic           sweep
);

	localparam int CODE_LIMIT = (DICT_SIZE < CODE_SPACE) ? DICT_SIZE : CODE_SPACE;
	localparam int DICT_AW    = $clog2(CODE_LIMIT);
	localparam int HASH_AW    = DICT_AW + 1;
	localparam int HASH_DEPTH = 2 ** HASH_AW;
	localparam int ENTRY_W    = PAIR_W + HASH_AW;

	// slot table holds codes, dictionary entry holds pair and owning slot
	logic [CODE_W-1:0]  slot_mem [HASH_DEPTH];
	logic [ENTRY_W-1:0] dict_mem [CODE_LIMIT];

	core_state_t        state_q, state_d;
	logic [CODE_W-1:0]  prefix_q, prefix_d;
	logic               present_q, present_d;
	logic [NFC_W-1:0]   nfc_q, nfc_d;
	logic [BYTE_W-1:0]  byte_q, byte_d;
	logic               eos_q, eos_d;
	logic [HASH_AW-1:0] idx_q, idx_d;
	logic [HASH_AW-1:0] clr_q, clr_d;
	logic [CODE_W-1:0]  slot_rd_q;
	logic [ENTRY_W-1:0] ent_rd_q;

	logic               slot_re;
	logic [HASH_AW-1:0] slot_raddr;
	logic               slot_we;
	logic [HASH_AW-1:0] slot_waddr;
	logic [CODE_W-1:0]  slot_wdata;
	logic               dict_we;
	logic [PAIR_W-1:0]  pair;
	logic [PAIR_W-1:0]  ent_pair;
	logic [HASH_AW-1:0] ent_slot;
	logic               live;

	function automatic logic [HASH_AW-1:0] pair_hash(input logic [CODE_W-1:0] p,
			input logic [BYTE_W-1:0] b);
		return HASH_AW'(p) ^ HASH_AW'(p >> HASH_AW) ^ (HASH_AW'(b) << (HASH_AW - BYTE_W));
	endfunction

	assign pair     = {prefix_q, byte_q};
	assign ent_pair = ent_rd_q[ENTRY_W-1 -: PAIR_W];
	assign ent_slot = ent_rd_q[HASH_AW-1:0];
	// a slot counts only if its code was assigned in this stream and points back to it
	assign live     = (slot_rd_q >= CODE_W'(FIRST_LEARNED))
		&& ({1'b0, slot_rd_q} < nfc_q) && (ent_slot == idx_q);
	assign sweep    = state_q == ST_CLEAR;

	always_comb begin
		state_d    = state_q;
		prefix_d   = prefix_q;
		present_d  = present_q;
		nfc_d      = nfc_q;
		byte_d     = byte_q;
		eos_d      = eos_q;
		idx_d      = idx_q;
		clr_d      = clr_q;
		item_pop   = 1'b0;
		res_push   = 1'b0;
		res        = '{code_word: prefix_q, last_code: 1'b0};
		slot_re    = 1'b0;
		slot_raddr = idx_q + 1'b1;
		slot_we    = 1'b0;
		slot_waddr = idx_q;
		slot_wdata = nfc_q[CODE_W-1:0];
		dict_we    = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				slot_we    = 1'b1;
				slot_waddr = clr_q;
				slot_wdata = '0;
				clr_d      = clr_q + 1'b1;
				if (clr_q == HASH_AW'(HASH_DEPTH - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				slot_raddr = pair_hash(prefix_q, item.data_byte);
				if (item_valid && res_room) begin
					item_pop = 1'b1;
					byte_d   = item.data_byte;
					eos_d    = item.end_of_stream;
					if (!present_q) begin
						prefix_d  = CODE_W'(item.data_byte);
						present_d = 1'b1;
						state_d   = item.end_of_stream ? ST_LAST : ST_IDLE;
					end else begin
						slot_re = 1'b1;
						idx_d   = slot_raddr;
						state_d = ST_DICT;
					end
				end
			end
			ST_DICT: begin
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (live && ent_pair == pair) begin
					prefix_d = slot_rd_q;
					state_d  = eos_q ? ST_LAST : ST_IDLE;
				end else if (live) begin
					// occupied by another pair, step to the next slot
					slot_re = 1'b1;
					idx_d   = slot_raddr;
					state_d = ST_DICT;
				end else begin
					res_push = 1'b1;
					if (nfc_q < NFC_W'(CODE_LIMIT)) begin
						slot_we = 1'b1;
						dict_we = 1'b1;
						nfc_d   = nfc_q + 1'b1;
					end
					prefix_d = CODE_W'(byte_q);
					state_d  = eos_q ? ST_LAST : ST_IDLE;
				end
			end
			ST_LAST: begin
				res_push  = 1'b1;
				res       = '{code_word: prefix_q, last_code: 1'b1};
				prefix_d  = '0;
				present_d = 1'b0;
				nfc_d     = NFC_W'(FIRST_LEARNED);
				state_d   = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (slot_we) begin
			slot_mem[slot_waddr] <= slot_wdata;
		end
		if (slot_re) begin
			slot_rd_q <= slot_mem[slot_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (dict_we) begin
			dict_mem[nfc_q[DICT_AW-1:0]] <= {pair, idx_q};
		end
		ent_rd_q <= dict_mem[slot_rd_q[DICT_AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			prefix_q  <= '0;
			present_q <= 1'b0;
			nfc_q     <= NFC_W'(FIRST_LEARNED);
			clr_q     <= '0;
		end else begin
			state_q   <= state_d;
			prefix_q  <= prefix_d;
			present_q <= present_d;
			nfc_q     <= nfc_d;
			clr_q     <= clr_d;
		end
	end

	always_ff @(posedge clk) begin
		byte_q <= byte_d;
		eos_q  <= eos_d;
		idx_q  <= idx_d;
	end

	a_nfc_range: assert property (@(posedge clk) disable iff (!arst_n)
		nfc_q >= NFC_W'(FIRST_LEARNED) && nfc_q <= NFC_W'(CODE_LIMIT))
		else $error("next free code out of range");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LAST |=> !present_q && nfc_q == NFC_W'(FIRST_LEARNED))
		else $error("stream end did not restart the dictionary");

	a_prefix_from_item: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(present_q) |-> $past(item_pop))
		else $error("prefix set without an item");

	a_dict_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DICT |-> $past(slot_re))
		else $error("dictionary stage entered without a slot read");

endmodule
`default_nettype wire

>>> tb/lzw_byte_encoder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lzw_byte_encoder_tb
// Drives byte streams into the encoder and checks every emitted code against
// a software lzw model kept in step with the accepted bytes. Covers single
// byte streams, repeats, stalls on both sides and a stream long enough to
// freeze the dictionary.
// ----------------------------------------------------------------------------
module lzw_byte_encoder_tb;
	import lzwe_pkg::*;

	// small dictionary so that one short stream reaches the freeze
	localparam int TB_DICT_SIZE = 512;
	localparam int CODE_LIMIT   = (TB_DICT_SIZE < CODE_SPACE) ? TB_DICT_SIZE : CODE_SPACE;
	localparam int STALL_CYCLES = 400;
	localparam int IDLE_PCT     = 27;
	localparam int FILL_BYTES   = 280;
	localparam int REPLAY_BYTES = 40;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [BYTE_W-1:0] data_byte = '0;
	logic              end_of_stream = 1'b0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [CODE_W-1:0] code_word;
	logic              last_code;

	lzw_byte_encoder #(
		.DICT_SIZE(TB_DICT_SIZE)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.end_of_stream(end_of_stream),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.code_word(code_word),
		.last_code(last_code)
	);

	// stimulus and expectation stores
	in_item_t  byte_feed[$];
	out_item_t pending_codes[$];
	in_item_t  next_byte;

	// lzw model state
	logic [CODE_W-1:0] cur_prefix = '0;
	bit                have_prefix = 1'b0;
	logic [NFC_W-1:0]  next_code = NFC_W'(FIRST_LEARNED);
	logic [CODE_W-1:0] code_of_pair[int];

	bit          quiet = 1'b0;
	bit          stall_req = 1'b0;
	int          stall_cnt = 0;
	bit          took_item = 1'b0;
	int unsigned items_queued = 0;
	int unsigned items_taken = 0;
	int unsigned codes_checked = 0;
	int unsigned streams_done = 0;
	int unsigned mismatch_count = 0;
	bit          dict_froze = 1'b0;
	int unsigned top_code = 0;

	initial begin
		forever #6 clk = ~clk;
	end

	task automatic lzw_predict(input logic [BYTE_W-1:0] b, input logic eos);
		int        key;
		out_item_t r;
		if (!have_prefix) begin
			cur_prefix  = CODE_W'(b);
			have_prefix = 1'b1;
		end else begin
			key = int'({cur_prefix, b});
			if (code_of_pair.exists(key)) begin
				cur_prefix = code_of_pair[key];
			end else begin
				r.code_word = cur_prefix;
				r.last_code = 1'b0;
				pending_codes = {pending_codes, r};
				if (next_code < CODE_LIMIT) begin
					code_of_pair[key] = next_code[CODE_W-1:0];
					next_code++;
				end else begin
					dict_froze = 1'b1;
				end
				cur_prefix = CODE_W'(b);
			end
		end
		if (eos) begin
			r.code_word = cur_prefix;
			r.last_code = 1'b1;
			pending_codes = {pending_codes, r};
			cur_prefix  = '0;
			have_prefix = 1'b0;
			next_code   = NFC_W'(FIRST_LEARNED);
			code_of_pair.delete();
			streams_done++;
		end
	endtask

	function automatic void note_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("[%0t] mismatch: %s", $realtime, msg);
	endfunction

	// input driver
	always @(negedge clk) begin
		if (arst_n && (!in_valid || took_item)) begin
			if (byte_feed.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
				next_byte = byte_feed.pop_front();
				in_valid      <= 1'b1;
				data_byte     <= next_byte.data_byte;
				end_of_stream <= next_byte.end_of_stream;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver side, with one long hold-off on request
	always @(negedge clk) begin
		if (stall_req && stall_cnt < STALL_CYCLES) begin
			out_ready <= 1'b0;
			stall_cnt++;
		end else begin
			out_ready <= arst_n && (quiet || $urandom_range(99) >= IDLE_PCT);
		end
	end

	// monitor: feed the model with accepted bytes, check accepted codes
	always @(posedge clk) begin
		out_item_t want;
		took_item <= arst_n && in_valid && in_ready;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				items_taken++;
				lzw_predict(data_byte, end_of_stream);
			end
			if (out_valid && out_ready) begin
				codes_checked++;
				if (32'(code_word) > top_code)
					top_code = 32'(code_word);
				if (pending_codes.size() == 0) begin
					note_mismatch($sformatf("unexpected code %0d last %0b",
						code_word, last_code));
				end else begin
					want = pending_codes.pop_front();
					if (want.code_word !== code_word || want.last_code !== last_code)
						note_mismatch($sformatf("code exp %0d/%0b got %0d/%0b",
							want.code_word, want.last_code, code_word, last_code));
				end
			end
		end
	end

	task automatic push_byte(input logic [BYTE_W-1:0] b, input logic eos);
		in_item_t it;
		it.data_byte     = b;
		it.end_of_stream = eos;
		byte_feed = {byte_feed, it};
		items_queued++;
	endtask

	task automatic push_list(input logic [BYTE_W-1:0] bytes[$]);
		foreach (bytes[i])
			push_byte(bytes[i], i == bytes.size() - 1);
	endtask

	// stream over a few symbols so that learned codes get reused, or over all bytes
	task automatic push_random_stream(input int len, input int symbols);
		logic [BYTE_W-1:0] alpha[$];
		repeat (symbols)
			alpha = {alpha, BYTE_W'($urandom_range(255))};
		for (int i = 0; i < len; i++) begin
			if (symbols == 0)
				push_byte(BYTE_W'($urandom_range(255)), i == len - 1);
			else
				push_byte(alpha[$urandom_range(symbols - 1)], i == len - 1);
		end
	endtask

	task automatic push_random_block(input int total);
		int start;
		start = items_queued;
		while (items_queued - start < total)
			push_random_stream($urandom_range(1, 40),
				($urandom_range(3) == 0) ? 0 : $urandom_range(1, 4));
	endtask

	task automatic wait_drained();
		while (items_taken != items_queued || pending_codes.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	initial begin
		logic [BYTE_W-1:0] fill[$];
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: lone byte, eos on a hit, extremes, repeated pattern
		push_list('{8'h41});
		push_list('{8'h00, 8'h00, 8'h00});
		push_list('{8'hff, 8'hff, 8'hff, 8'hff});
		push_list('{8'h41, 8'h42, 8'h41, 8'h42, 8'h41, 8'h42, 8'h41});
		push_list('{8'h80, 8'h7f, 8'h01, 8'hfe});
		wait_drained();

		// receiver holds off while the sender keeps offering
		quiet = 1'b1;
		stall_req = 1'b1;
		push_random_block(60);
		wait (stall_cnt == STALL_CYCLES);
		wait_drained();

		// no idling on either side
		push_random_block(120);
		wait_drained();
		quiet = 1'b0;

		push_random_block(280);
		wait_drained();

		// one long stream to fill and freeze the dictionary, then replay its head
		for (int i = 0; i < FILL_BYTES; i++)
			fill = {fill, BYTE_W'($urandom_range(255))};
		for (int i = 0; i < REPLAY_BYTES; i++)
			fill = {fill, fill[i]};
		push_list(fill);
		wait_drained();

		repeat (50) @(posedge clk);
		if (pending_codes.size() != 0)
			mismatch_count += pending_codes.size();
		$display("covered %0d bytes in %0d streams, %0d codes checked, top code %0d",
			items_taken, streams_done, codes_checked, top_code);
		$display("dictionary freeze reached: %s", dict_froze ? "yes" : "no");
		if (mismatch_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin
		#12_000_000;
		$display("timeout: %0d of %0d bytes taken, %0d codes outstanding",
			items_taken, items_queued, pending_codes.size());
		$display("end of test: mismatches");
		$finish;
	end

endmodule
